/* rtl/ttcs_pkg.sv */
package ttcs_pkg;

   localparam int unsigned CNT_W = 32;
   localparam int unsigned CPT_W = 16;

   localparam logic [CNT_W-1:0] FULL32 = 32'hFFFF_FFFF;

   localparam logic [CPT_W-1:0] CPT_RESET  = 16'd327;
   localparam logic             MODE_RESET = 1'b1;

   // command codes
   localparam logic [1:0] CMD_COMPARE = 2'd0;
   localparam logic [1:0] CMD_SET_TMO = 2'd1;
   localparam logic [1:0] CMD_ELAPSED = 2'd2;
   localparam logic [1:0] CMD_INIT    = 2'd3;

   // configuration register indexes
   localparam logic REG_CYCLES_PER_TICK = 1'b0;
   localparam logic REG_TICKLESS_MODE   = 1'b1;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] dividend;
      logic [CPT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] quot;
      logic [CPT_W-1:0] rem;
   } div_rsp_type;

endpackage

/* rtl/ttcs_div.sv */
// Restoring divider, 32 by 16 bits, one quotient bit per cycle.
module ttcs_div import ttcs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0] quot_ff, quot_in;
   logic [CPT_W-1:0] rem_ff, rem_in;
   logic [CPT_W-1:0] dvs_ff, dvs_in;

   logic [CPT_W:0]   shifted;
   logic [CPT_W+1:0] diff;
   logic             ge;

   assign shifted = {rem_ff, quot_ff[CNT_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};
   assign ge      = ~diff[CPT_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         quot_in = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[CNT_W-2:0], ge};
         rem_in  = ge ? diff[CPT_W-1:0] : shifted[CPT_W-1:0];
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

/* rtl/tick_timeout_compare_scheduler.sv */
// Channel   Dir  Transfer when          Payload
// req_*     in   tvalid & tready        tuser: cmd; tdata: now, reread, timeout_ticks
// rsp_*     out  tvalid & tready        tdata: announce, delta, wr, force, elapsed
// csr_*     in   csr_we                 index 0 cycles_per_tick, 1 tickless_mode
//
// Init requests go straight to the result; compare event and elapsed query make
// one pass through the shared 32-step divider, set timeout two. The next request
// can transfer in the same cycle that the loaded result raises rsp_tvalid.
// Reset is synchronous, active high; last_count clears to zero.
// req_tready is high only while idle; a finished result may wait in the
// output register while the next request is taken, and a second finished
// result waits in place until that register frees up.
module tick_timeout_compare_scheduler import ttcs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // request
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // [1:0] cmd
   input  logic [95:0]  req_tdata,   // [31:0] counter_now, [63:32] counter_reread,
                                     // [95:64] timeout_ticks
   // result
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [31:0] announce_ticks, [63:32] compare_delta,
                                     // [64] write_compare, [65] force_interrupt,
                                     // [97:66] elapsed_ticks, [103:98] zero
   // configuration
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV_MAX, S_MUL_MAX, S_DIV_E, S_MUL, S_DONE
   } state_type;

   state_type        state_ff, state_in;

   logic [CPT_W-1:0] cpt_ff, cpt_in;
   logic             mode_ff, mode_in;
   logic [CNT_W-1:0] last_ff, last_in;

   // captured request and intermediates
   logic [1:0]       cmd_ff, cmd_in;
   logic [CNT_W-1:0] now_ff, now_in;
   logic [CNT_W-1:0] reread_ff, reread_in;
   logic [CNT_W-1:0] tmo_ff, tmo_in;
   logic [CNT_W-1:0] e_ff, e_in;
   logic [CNT_W-1:0] q_ff, q_in;
   logic [CPT_W-1:0] r_ff, r_in;
   logic [CNT_W-1:0] mt_ff, mt_in;
   logic [CNT_W-1:0] maxc_ff, maxc_in;
   logic [CNT_W-1:0] prod_ff, prod_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] announce_ff, announce_in;
   logic [CNT_W-1:0] delta_ff, delta_in;
   logic             wr_ff, wr_in;
   logic             force_ff, force_in;
   logic [CNT_W-1:0] elapsed_ff, elapsed_in;

   logic                   req_xfer;
   logic                   out_free;
   logic [CPT_W-1:0]       c_eff;
   logic [CNT_W-1:0]       e_now;
   logic [CNT_W-1:0]       t_clamp;
   logic [CNT_W-1:0]       mul_a;
   logic [CNT_W+CPT_W-1:0] mul_full;
   logic [CNT_W:0]         n_sum;
   logic [CNT_W-1:0]       d_val;
   logic [CNT_W-1:0]       nxt;
   logic [CNT_W-1:0]       pdelta;

   div_req_type div_req;
   div_rsp_type div_rsp;

   ttcs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // zero tick length acts as one
   assign c_eff = (cpt_ff == '0) ? {{(CPT_W-1){1'b0}}, 1'b1} : cpt_ff;
   assign e_now = req_tdata[31:0] - last_ff;

   // timeout request clamp: forever -> max, below one -> one, above max -> max
   always_comb begin
      if (tmo_ff == FULL32) begin
         t_clamp = mt_ff;
      end else if (tmo_ff[CNT_W-1] || tmo_ff == '0) begin
         t_clamp = {{(CNT_W-1){1'b0}}, 1'b1};
      end else if (tmo_ff > mt_ff) begin
         t_clamp = mt_ff;
      end else begin
         t_clamp = tmo_ff;
      end
   end

   // the one multiplier: max span, timeout cycles, or announced cycles
   always_comb begin
      if (state_ff == S_MUL_MAX) begin
         mul_a = mt_ff;
      end else if (cmd_ff == CMD_SET_TMO) begin
         mul_a = t_clamp;
      end else begin
         mul_a = q_ff;
      end
   end
   assign mul_full = mul_a * c_eff;

   // divider launch: full range for the max tick count, else elapsed cycles
   always_comb begin
      div_req.divisor = c_eff;
      if (state_ff == S_MUL_MAX) begin
         div_req.start    = 1'b1;
         div_req.dividend = e_ff;
      end else begin
         div_req.start    = req_xfer && (req_tuser != CMD_INIT);
         div_req.dividend = (req_tuser == CMD_SET_TMO) ? FULL32 : e_now;
      end
   end

   // set-timeout span; prod_ff holds t*C, aligned span is t*C - (e mod C)
   assign n_sum = {1'b0, e_ff} + {1'b0, prod_ff};
   always_comb begin
      if (maxc_ff < e_ff) begin
         d_val = {{(CNT_W-1){1'b0}}, 1'b1};
      end else if ({1'b0, maxc_ff} <= n_sum) begin
         d_val = maxc_ff - e_ff;
      end else begin
         d_val = prod_ff - {{(CNT_W-CPT_W){1'b0}}, r_ff};
      end
   end

   // periodic compare: next boundary after the announced ticks
   assign nxt    = now_ff + prod_ff + {{(CNT_W-CPT_W){1'b0}}, c_eff};
   assign pdelta = nxt - reread_ff;

   always_comb begin
      state_in     = state_ff;
      cpt_in       = cpt_ff;
      mode_in      = mode_ff;
      last_in      = last_ff;
      cmd_in       = cmd_ff;
      now_in       = now_ff;
      reread_in    = reread_ff;
      tmo_in       = tmo_ff;
      e_in         = e_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      mt_in        = mt_ff;
      maxc_in      = maxc_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      announce_in  = announce_ff;
      delta_in     = delta_ff;
      wr_in        = wr_ff;
      force_in     = force_ff;
      elapsed_in   = elapsed_ff;

      if (csr_we) begin
         unique case (csr_index)
            REG_CYCLES_PER_TICK: cpt_in  = csr_wdata;
            REG_TICKLESS_MODE:   mode_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in    = req_tuser;
               now_in    = req_tdata[31:0];
               reread_in = req_tdata[63:32];
               tmo_in    = req_tdata[95:64];
               e_in      = e_now;
               unique case (req_tuser)
                  CMD_SET_TMO: state_in = S_DIV_MAX;
                  CMD_INIT:    state_in = S_DONE;
                  default:     state_in = S_DIV_E;
               endcase
            end
         end
         S_DIV_MAX: begin
            if (div_rsp.done) begin
               mt_in    = div_rsp.quot - 32'd1;
               state_in = S_MUL_MAX;
            end
         end
         S_MUL_MAX: begin
            maxc_in  = mul_full[CNT_W-1:0];
            state_in = S_DIV_E;
         end
         S_DIV_E: begin
            if (div_rsp.done) begin
               q_in     = div_rsp.quot;
               r_in     = div_rsp.rem;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = mul_full[CNT_W-1:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               announce_in  = '0;
               delta_in     = '0;
               wr_in        = 1'b0;
               force_in     = 1'b0;
               elapsed_in   = '0;
               unique case (cmd_ff)
                  CMD_COMPARE: begin
                     if (mode_ff) begin
                        announce_in = q_ff;
                        last_in     = last_ff + prod_ff;
                     end else begin
                        wr_in = 1'b1;
                        if (pdelta == '0) begin
                           // compare already due: announce one more tick
                           announce_in = q_ff + 32'd1;
                           last_in     = last_ff + prod_ff
                                         + {{(CNT_W-CPT_W){1'b0}}, c_eff};
                           delta_in    = {{(CNT_W-CPT_W){1'b0}}, c_eff};
                        end else begin
                           announce_in = q_ff;
                           last_in     = last_ff + prod_ff;
                           delta_in    = pdelta;
                        end
                     end
                  end
                  CMD_SET_TMO: begin
                     if (mode_ff) begin
                        if (d_val <= 32'd1) begin
                           force_in = 1'b1;
                        end else begin
                           delta_in = d_val;
                           wr_in    = 1'b1;
                        end
                     end
                  end
                  CMD_ELAPSED: begin
                     if (mode_ff) begin
                        elapsed_in = q_ff;
                     end
                  end
                  CMD_INIT: begin
                     last_in = now_ff;
                     if (!mode_ff) begin
                        delta_in = {{(CNT_W-CPT_W){1'b0}}, c_eff};
                        wr_in    = 1'b1;
                     end
                  end
                  default: ;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cpt_ff       <= CPT_RESET;
         mode_ff      <= MODE_RESET;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cpt_ff       <= cpt_in;
         mode_ff      <= mode_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      now_ff      <= now_in;
      reread_ff   <= reread_in;
      tmo_ff      <= tmo_in;
      e_ff        <= e_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      mt_ff       <= mt_in;
      maxc_ff     <= maxc_in;
      prod_ff     <= prod_in;
      announce_ff <= announce_in;
      delta_ff    <= delta_in;
      wr_ff       <= wr_in;
      force_ff    <= force_in;
      elapsed_ff  <= elapsed_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, elapsed_ff, force_ff, wr_ff, delta_ff, announce_ff};

endmodule

/* rtl/ttcs_checker.sv */
module ttcs_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one request at a time
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after request transfer");

   a_wr_force_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[64] && rsp_tdata[65]))
      else $error("write_compare and force_interrupt together");

   a_force_zero_delta: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[65] |-> rsp_tdata[63:32] == 32'd0)
      else $error("forced interrupt with nonzero delta");

   a_wr_nonzero_delta: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> rsp_tdata[63:32] != 32'd0)
      else $error("compare write with zero delta");

endmodule

bind tick_timeout_compare_scheduler ttcs_checker u_ttcs_checker (.*);

/* test/tick_timeout_compare_scheduler_tb.sv */
module tick_timeout_compare_scheduler_tb import ttcs_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;   // generous hang guard
   localparam int HOLD_CYCLES = 400;       // long receiver hold-off
   localparam int SEGMENTS    = 10;        // random phases, one setting each
   localparam int SEG_ITEMS   = 100;       // requests per random phase

   // Result transfer as laid out on rsp_tdata, MSB first.
   typedef struct packed {
      logic [5:0]  pad;
      logic [31:0] elapsed;
      logic        force_irq;
      logic        write_cmp;
      logic [31:0] delta;
      logic [31:0] announce;
   } sched_rsp_type;

   // Per-request note: a typed-in result replaces the prediction.
   typedef struct {
      bit            typed;
      sched_rsp_type want;
   } row_want_type;

   // Directed table row: either a register setting or a request.
   typedef struct {
      bit            is_cfg;
      logic [15:0]   cpt;
      logic          mode;
      logic [1:0]    cmd;
      logic [31:0]   now;
      logic [31:0]   reread;
      logic [31:0]   tmo;
      bit            typed;
      sched_rsp_type want;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = CMD_COMPARE;   // [1:0] cmd
   logic [95:0]  req_tdata = '0;            // [31:0] now, [63:32] reread, [95:64] timeout
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;                 // [31:0] announce, [63:32] delta, [64] write,
                                            // [65] force, [97:66] elapsed, [103:98] zero
   logic         csr_we = 1'b0;
   logic         csr_index = REG_CYCLES_PER_TICK;
   logic [15:0]  csr_wdata = '0;

   // Shadow of the block: stored counter and the two registers.
   logic [31:0]  pred_last = '0;
   logic [15:0]  pred_cpt = CPT_RESET;
   logic         pred_mode = MODE_RESET;

   sched_rsp_type due_rsp_q[$];     // results still owed by the block, oldest first
   row_want_type  row_want_q[$];    // notes for requests on the wire
   stim_row_type  stim_table[$];

   int           err_count = 0;
   int           n_checked = 0;
   int           n_forced = 0;
   int           n_writes = 0;
   int           n_settings = 0;
   int           n_cmd[4] = '{0, 0, 0, 0};
   int           cycle_count = 0;

   // Idle knobs, set per phase by the main sequence.
   int           send_idle_pct = 0;
   int           rcv_idle_pct = 0;
   bit           hold_arm = 1'b0;
   bit           hold_done = 1'b0;
   int           hold_left = 0;

   logic [31:0]  cursor = '0;      // stimulus-side counter, advanced per random request

   tick_timeout_compare_scheduler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hang guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results owed", cycle_count,
                  due_rsp_q.size());
         $display("tick_timeout_compare_scheduler_tb: done, errors");
         $finish;
      end
   end

   // Expected result for one accepted request; advances the shadow state.
   function automatic sched_rsp_type predict_schedule(input logic [1:0] cmd,
                                                      input logic [31:0] now,
                                                      input logic [31:0] reread,
                                                      input logic [31:0] tmo);
      sched_rsp_type   r;
      logic [31:0]     c;
      logic [31:0]     e;
      logic [31:0]     ticks;
      logic [31:0]     nxt;
      longint unsigned max_t;
      longint unsigned max_c;
      longint unsigned t;
      longint unsigned n;
      longint unsigned d;
      r = '0;
      c = (pred_cpt == 16'd0) ? 32'd1 : 32'(pred_cpt);   // zero tick length acts as one
      e = now - pred_last;                               // modulo 2^32
      case (cmd)
         CMD_COMPARE: begin
            ticks = e / c;
            if (!pred_mode) begin
               nxt = now + (ticks + 32'd1) * c;
               r.delta = nxt - reread;
               // compare already due: announce one more tick, arm a full one
               if (r.delta == 32'd0) begin
                  ticks = ticks + 32'd1;
                  r.delta = c;
               end
               r.write_cmp = 1'b1;
            end
            pred_last = pred_last + ticks * c;
            r.announce = ticks;
         end
         CMD_SET_TMO: begin
            if (pred_mode) begin
               max_t = 64'(FULL32 / c) - 64'd1;
               max_c = max_t * 64'(c);
               if (tmo == FULL32) begin          // forever
                  t = max_t;
               end else if ($signed(tmo) < 1) begin
                  t = 64'd1;
               end else if (64'(tmo) > max_t) begin
                  t = max_t;
               end else begin
                  t = 64'(tmo);
               end
               n = 64'(e) + t * 64'(c);
               if (max_c < 64'(e)) begin
                  d = 64'd1;
               end else if (max_c <= n) begin
                  d = max_c - 64'(e);
               end else begin
                  d = (n / 64'(c)) * 64'(c) - 64'(e);
               end
               if (d <= 64'd1) begin
                  r.force_irq = 1'b1;
               end else begin
                  r.delta = d[31:0];
                  r.write_cmp = 1'b1;
               end
            end
         end
         CMD_ELAPSED: begin
            if (pred_mode) begin
               r.elapsed = e / c;
            end
         end
         CMD_INIT: begin
            pred_last = now;
            if (!pred_mode) begin
               r.delta = c;
               r.write_cmp = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   function automatic sched_rsp_type mk_rsp(input logic [31:0] ann, input logic [31:0] dlt,
                                            input logic wr, input logic frc,
                                            input logic [31:0] ela);
      sched_rsp_type r;
      r = '0;
      r.announce = ann;
      r.delta = dlt;
      r.write_cmp = wr;
      r.force_irq = frc;
      r.elapsed = ela;
      return r;
   endfunction

   function automatic void add_cfg(input logic [15:0] cpt, input logic mode);
      stim_row_type row;
      row = '{default: '0};
      row.is_cfg = 1'b1;
      row.cpt = cpt;
      row.mode = mode;
      stim_table.push_back(row);
   endfunction

   function automatic void add_req(input logic [1:0] cmd, input logic [31:0] now,
                                   input logic [31:0] reread, input logic [31:0] tmo,
                                   input bit typed, input sched_rsp_type want);
      stim_row_type row;
      row = '{default: '0};
      row.cmd = cmd;
      row.now = now;
      row.reread = reread;
      row.tmo = tmo;
      row.typed = typed;
      row.want = want;
      stim_table.push_back(row);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at result %0d, %s: got %h want %h", n_checked, what, got, want);
      err_count++;
   endtask

   // Result checker and request monitor. The checker runs first so that a result
   // and a new request transferring on the same edge never race on the queue.
   always @(posedge clock) begin : monitor
      sched_rsp_type got;
      sched_rsp_type want;
      sched_rsp_type pred;
      row_want_type  note;
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == REG_CYCLES_PER_TICK) begin
               pred_cpt = csr_wdata;
            end else begin
               pred_mode = csr_wdata[0];
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = sched_rsp_type'(rsp_tdata);
            if (due_rsp_q.size() == 0) begin
               report_mismatch("result with none owed", got.announce, '0);
            end else begin
               want = due_rsp_q.pop_front();
               if (got.announce !== want.announce)
                  report_mismatch("announce_ticks", got.announce, want.announce);
               if (got.delta !== want.delta)
                  report_mismatch("compare_delta", got.delta, want.delta);
               if (got.write_cmp !== want.write_cmp)
                  report_mismatch("write_compare", 32'(got.write_cmp), 32'(want.write_cmp));
               if (got.force_irq !== want.force_irq)
                  report_mismatch("force_interrupt", 32'(got.force_irq), 32'(want.force_irq));
               if (got.elapsed !== want.elapsed)
                  report_mismatch("elapsed_ticks", got.elapsed, want.elapsed);
               if (got.pad !== 6'd0)
                  report_mismatch("pad bits", 32'(got.pad), '0);
               n_forced += want.force_irq;
               n_writes += want.write_cmp;
               n_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            note = row_want_q.pop_front();
            pred = predict_schedule(req_tuser, req_tdata[31:0], req_tdata[63:32],
                                    req_tdata[95:64]);
            due_rsp_q.push_back(note.typed ? note.want : pred);
            n_cmd[req_tuser]++;
         end
      end
   end

   // Receiver: random backpressure, plus one long hold-off counted here so the
   // block fills up and drops req_tready while the sender keeps offering.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // One request transfer; valid stays up afterwards unless the next call idles.
   task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] now,
                           input logic [31:0] reread, input logic [31:0] tmo,
                           input bit typed, input sched_rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      row_want_q.push_back('{typed, want});
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {tmo, reread, now};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drain: every owed result back, then a settling margin.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Both registers, back to back; only called once settled.
   task automatic set_config(input logic [15:0] cpt, input logic mode);
      csr_we <= 1'b1;
      csr_index <= REG_CYCLES_PER_TICK;
      csr_wdata <= cpt;
      @(posedge clock);
      csr_index <= REG_TICKLESS_MODE;
      csr_wdata <= {15'd0, mode};
      @(posedge clock);
      csr_we <= 1'b0;
      n_settings++;
   endtask

   // Mostly well-formed traffic: the counter creeps forward from the last init,
   // rereads land near the next tick, with a sprinkle of wild values.
   task automatic send_random_item();
      int unsigned c;
      int unsigned pick;
      logic [1:0]  cmd;
      logic [31:0] now;
      logic [31:0] reread;
      logic [31:0] tmo;
      c = (pred_cpt == 16'd0) ? 1 : int'(pred_cpt);
      if ($urandom_range(99) < 5) begin
         cursor = $urandom;
      end else begin
         cursor = cursor + $urandom_range(0, 3 * c);
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
         cmd = CMD_COMPARE;
      end else if (pick < 70) begin
         cmd = CMD_SET_TMO;
      end else if (pick < 85) begin
         cmd = CMD_ELAPSED;
      end else begin
         cmd = CMD_INIT;
      end
      now = cursor;
      pick = $urandom_range(99);
      if (pick < 50) begin
         reread = now + $urandom_range(0, c);
      end else if (pick < 65) begin
         // lands exactly on the next compare: zero delta in periodic mode
         reread = now + ((now - pred_last) / c + 1) * c;
      end else if (pick < 80) begin
         reread = now + $urandom_range(1, 3) * c;
      end else begin
         reread = $urandom;
      end
      pick = $urandom_range(99);
      if (pick < 30) begin
         tmo = $urandom_range(0, 20);
      end else if (pick < 45) begin
         tmo = FULL32;
      end else if (pick < 60) begin
         tmo = $urandom;
      end else if (pick < 70) begin
         tmo = $urandom | 32'h8000_0000;
      end else if (pick < 85) begin
         tmo = 32'h7FFF_FFFF - $urandom_range(0, 3);
      end else begin
         tmo = $urandom >> $urandom_range(0, 31);
      end
      send_cmd(cmd, now, reread, tmo, 1'b0, '0);
   endtask

   initial begin : main
      logic [15:0] seg_cpt;
      logic        seg_mode;

      // Directed table. After reset: cycles_per_tick at CPT_RESET, tickless, last = 0.
      add_req(CMD_ELAPSED, 32'd0, 32'd0, 32'd0, 1'b1, '0);
      add_req(CMD_INIT, 32'd0, 32'd0, 32'd0, 1'b1, '0);              // tickless init
      add_req(CMD_SET_TMO, 32'd0, 32'd0, 32'd0, 1'b1,
              mk_rsp(32'd0, 32'd327, 1'b1, 1'b0, 32'd0));
      add_req(CMD_SET_TMO, 32'd0, FULL32, 32'h8000_0000, 1'b1,
              mk_rsp(32'd0, 32'd327, 1'b1, 1'b0, 32'd0));
      add_req(CMD_SET_TMO, 32'd0, 32'd0, FULL32, 1'b0, '0);          // forever
      add_req(CMD_SET_TMO, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b0, '0);   // capped
      // elapsed beyond the longest span: fires at once
      add_req(CMD_SET_TMO, FULL32, 32'd0, 32'd5, 1'b1,
              mk_rsp(32'd0, 32'd0, 1'b0, 1'b1, 32'd0));
      // one count short of the boundary: delta of one, fires at once
      add_req(CMD_SET_TMO, 32'd326, 32'd0, 32'd1, 1'b1,
              mk_rsp(32'd0, 32'd0, 1'b0, 1'b1, 32'd0));
      add_req(CMD_ELAPSED, FULL32, 32'd0, 32'd0, 1'b0, '0);
      // counter equal to the stored value: nothing elapsed
      add_req(CMD_COMPARE, 32'd0, FULL32, 32'd0, 1'b1, '0);
      add_req(CMD_COMPARE, 32'd1000, 32'd0, 32'd0, 1'b1,
              mk_rsp(32'd3, 32'd0, 1'b0, 1'b0, 32'd0));
      add_req(CMD_INIT, 32'hFFFF_FF00, 32'd0, 32'd0, 1'b1, '0);
      add_req(CMD_COMPARE, 32'h0000_0100, 32'd0, 32'd0, 1'b0, '0);   // across the wrap
      add_cfg(16'd0, 1'b1);                                          // zero tick length
      add_req(CMD_ELAPSED, 32'd5, 32'd0, 32'd0, 1'b0, '0);
      add_req(CMD_SET_TMO, 32'd5, 32'd0, 32'd3, 1'b0, '0);
      add_cfg(16'hFFFF, 1'b0);                                       // periodic, longest tick
      add_req(CMD_INIT, 32'h1234_5678, 32'd0, 32'd0, 1'b1,
              mk_rsp(32'd0, 32'd65535, 1'b1, 1'b0, 32'd0));
      add_req(CMD_SET_TMO, 32'h1234_5678, 32'd0, 32'd7, 1'b1, '0);
      add_req(CMD_ELAPSED, 32'h2000_0000, 32'd0, 32'd0, 1'b1, '0);
      // reread sits right on the next compare: extra tick, full-tick delta
      add_req(CMD_COMPARE, 32'h1234_5678 + 32'd131075, 32'h1234_5678 + 32'd327680,
              32'd0, 1'b1, mk_rsp(32'd3, 32'd65535, 1'b1, 1'b0, 32'd0));
      add_req(CMD_COMPARE, 32'h1234_5678 + 32'd300000, 32'h1234_5678 + 32'd300010,
              32'd0, 1'b0, '0);
      add_cfg(16'd1, 1'b0);
      add_req(CMD_COMPARE, FULL32, 32'd0, 32'd0, 1'b0, '0);
      add_cfg(16'hFFFF, 1'b1);
      add_req(CMD_SET_TMO, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b0, '0);
      add_req(CMD_ELAPSED, FULL32, 32'd0, 32'd0, 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walk, receiver lightly throttled, sender never idle.
      rcv_idle_pct = 30;
      foreach (stim_table[i]) begin
         if (stim_table[i].is_cfg) begin
            settle();
            set_config(stim_table[i].cpt, stim_table[i].mode);
         end else begin
            send_cmd(stim_table[i].cmd, stim_table[i].now, stim_table[i].reread,
                     stim_table[i].tmo, stim_table[i].typed, stim_table[i].want);
         end
      end

      // Random phases: each pairs a tick length with a mode so that every
      // combination of the extremes shows up; idling shifts from a slow
      // receiver to a slow sender to none at all.
      for (int s = 0; s < SEGMENTS; s++) begin
         settle();
         case (s % 5)
            0: seg_cpt = CPT_RESET;
            1: seg_cpt = 16'd1;
            2: seg_cpt = 16'hFFFF;
            3: seg_cpt = 16'($urandom_range(2, 64));
            default: seg_cpt = 16'($urandom_range(2, 65534));
         endcase
         seg_mode = s[0];
         set_config(seg_cpt, seg_mode);
         if (s < 4) begin
            send_idle_pct = 12;
            rcv_idle_pct = 82;
         end else if (s < 7) begin
            send_idle_pct = 82;
            rcv_idle_pct = 12;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         if (s == 7) begin
            hold_arm = 1'b1;       // long stall while the sender runs flat out
         end
         cursor = $urandom;
         send_cmd(CMD_INIT, cursor, 32'd0, 32'd0, 1'b0, '0);
         for (int k = 1; k < SEG_ITEMS; k++) begin
            send_random_item();
         end
      end

      settle();
      repeat (80) @(posedge clock);
      if (due_rsp_q.size() != 0) begin
         report_mismatch("results never delivered", 32'(due_rsp_q.size()), '0);
      end

      $display("ran %0d compare, %0d set-timeout, %0d elapsed, %0d init requests",
               n_cmd[CMD_COMPARE], n_cmd[CMD_SET_TMO], n_cmd[CMD_ELAPSED],
               n_cmd[CMD_INIT]);
      $display("over %0d settings; checked %0d results: %0d writes, %0d forced, %0d bad",
               n_settings, n_checked, n_writes, n_forced, err_count);
      if (err_count == 0) begin
         $display("tick_timeout_compare_scheduler_tb: done, clean");
      end else begin
         $display("tick_timeout_compare_scheduler_tb: done, errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/ttcs_pkg.sv
rtl/ttcs_div.sv
rtl/tick_timeout_compare_scheduler.sv
rtl/ttcs_checker.sv
test/tick_timeout_compare_scheduler_tb.sv
